>>> rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared constants for the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_WORDS_DEF = 512;

	localparam int REQ_W     = 16;
	localparam int SLOT_W    = 9;
	localparam int NEED_W    = 14;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

endpackage

>>> rtl/core/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// header store: one write port, one registered read port; entry 0 reads as
// a single free block spanning the heap until it is first written
// ----------------------------------------------------------------------------
module ffha_hdr_mem #(
	parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
	parameter int IDX_W      = $clog2(HEAP_WORDS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [IDX_W-1:0] wr_size,
	input  logic             wr_busy,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] rd_size,
	output logic             rd_busy
);

	localparam logic [IDX_W-1:0] INIT_SIZE = IDX_W'(HEAP_WORDS - 1);

	logic [IDX_W:0]   mem [HEAP_WORDS];
	logic [IDX_W:0]   rd_data_q;
	logic             rd_zero_q;
	logic             zero_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_size, wr_busy};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_zero_q      <= 1'b0;
			zero_written_q <= 1'b0;
		end else begin
			rd_zero_q <= (rd_addr == '0);
			if (wr_en && wr_addr == '0) begin
				zero_written_q <= 1'b1;
			end
		end
	end

	always_comb begin
		if (rd_zero_q && !zero_written_q) begin
			rd_size = INIT_SIZE;
			rd_busy = 1'b0;
		end else begin
			rd_size = rd_data_q[IDX_W:1];
			rd_busy = rd_data_q[0];
		end
	end

endmodule

>>> rtl/core/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over a heap of 8-byte slots with one header per block
// ----------------------------------------------------------------------------
// An allocate walks the block headers from slot 0 at one header per clock,
// using a single shared adder to step to the next header. On a fit it writes
// the split remainder, if any, marks the block busy and posts the slot; if no
// block fits, it posts a failure. A free reads the header, writes it back as
// free and posts the result; a free of slot zero or beyond the heap skips the
// write. The input side is ready only while idle, so a new request waits until
// the last result is in the output register.
module first_fit_heap_allocator #(
	parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// request_size [15:0], block_slot [24:16], zero [31:25]
	input  logic [ffha_pkg::S_TDATA_W-1:0] s_tdata,
	// operation [0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// payload_slot [8:0], zero [15:9]
	output logic [ffha_pkg::M_TDATA_W-1:0] m_tdata,
	// status [0]
	output logic                           m_tuser
);

	localparam int IDX_W  = $clog2(HEAP_WORDS);
	localparam int NEED_W = ffha_pkg::NEED_W;
	localparam int SLOT_W = ffha_pkg::SLOT_W;
	localparam int REQ_W  = ffha_pkg::REQ_W;
	localparam int CW     = (IDX_W > NEED_W ? IDX_W : NEED_W) + 1;
	localparam logic [CW-1:0] HEAP_END = CW'(HEAP_WORDS);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHECK   = 3'd1;
	localparam logic [2:0] ST_SPLIT   = 3'd2;
	localparam logic [2:0] ST_MARK    = 3'd3;
	localparam logic [2:0] ST_FREE_WR = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  nxt_q;
	logic [NEED_W-1:0] need_q;
	logic [IDX_W-1:0]  rem_q;
	logic              res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              m_tvalid_q;
	logic              m_status_q;
	logic [SLOT_W-1:0] m_slot_q;

	logic [REQ_W-1:0]  in_req;
	logic [SLOT_W-1:0] in_slot;
	logic              in_fire;
	logic [REQ_W:0]    req_round;
	logic [NEED_W-1:0] in_need;
	logic              free_ok;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  wr_size;
	logic              wr_busy;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  rd_size;
	logic              rd_busy;

	logic              fits;
	logic [CW-1:0]     add_b;
	logic [CW-1:0]     step_sum;
	logic              out_free;

	assign in_req    = s_tdata[REQ_W-1:0];
	assign in_slot   = s_tdata[REQ_W +: SLOT_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign req_round = {1'b0, in_req} + (REQ_W+1)'(7);
	assign in_need   = req_round[REQ_W:3];
	assign free_ok   = (in_slot != '0) && (CW'(in_slot) < HEAP_END);

	// shared step adder: next header after the block, or split point
	assign fits     = !rd_busy && (CW'(rd_size) >= CW'(need_q));
	assign add_b    = fits ? CW'(need_q) : CW'(rd_size);
	assign step_sum = CW'(idx_q) + add_b + CW'(1);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		rd_addr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tuser == ffha_pkg::OP_FREE) begin
					rd_addr = IDX_W'(CW'(in_slot) - CW'(1));
				end else begin
					rd_addr = '0;
				end
			end
			ST_CHECK: rd_addr = step_sum[IDX_W-1:0];
			default:  rd_addr = idx_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_size = rd_size;
		wr_busy = 1'b0;
		unique case (state_q)
			ST_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = nxt_q;
				wr_size = rem_q;
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_size = IDX_W'(need_q);
				wr_busy = 1'b1;
			end
			ST_FREE_WR: begin
				wr_en = 1'b1;
			end
			default: wr_en = 1'b0;
		endcase
	end

	ffha_hdr_mem #(
		.HEAP_WORDS(HEAP_WORDS),
		.IDX_W     (IDX_W)
	) u_hdr_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_size(wr_size),
		.wr_busy(wr_busy),
		.rd_addr(rd_addr),
		.rd_size(rd_size),
		.rd_busy(rd_busy)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				need_q       <= in_need;
				idx_q        <= rd_addr;
				res_status_q <= ffha_pkg::STATUS_OK;
				res_slot_q   <= '0;
			end
			ST_CHECK: begin
				if (fits) begin
					nxt_q      <= step_sum[IDX_W-1:0];
					rem_q      <= IDX_W'(CW'(rd_size) - CW'(need_q) - CW'(1));
					res_slot_q <= SLOT_W'(CW'(idx_q) + CW'(1));
				end else if (step_sum >= HEAP_END) begin
					res_status_q <= ffha_pkg::STATUS_FAIL;
					res_slot_q   <= '0;
				end else begin
					idx_q <= step_sum[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			m_status_q <= res_status_q;
			m_slot_q   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == ffha_pkg::OP_ALLOC) begin
							state_q <= ST_CHECK;
						end else if (free_ok) begin
							state_q <= ST_FREE_WR;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CHECK: begin
					if (fits) begin
						if (CW'(rd_size) > CW'(need_q) && step_sum < HEAP_END) begin
							state_q <= ST_SPLIT;
						end else begin
							state_q <= ST_MARK;
						end
					end else if (step_sum >= HEAP_END) begin
						state_q <= ST_DONE;
					end
				end
				ST_SPLIT:   state_q <= ST_MARK;
				ST_MARK:    state_q <= ST_DONE;
				ST_FREE_WR: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ffha_pkg::M_TDATA_W'(m_slot_q);
	assign m_tuser  = m_status_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the first-fit heap allocator
// ----------------------------------------------------------------------------
// Requests are planned against a shadow heap, so frees can target live blocks.
// They are sent through the slave stream with random gaps, and each accepted
// request is run through a second heap copy to predict its result. Results are
// compared in order on the master stream, which stalls at random. One long
// hold-off on the master side forces the block to back up its input.
module tb_top;

	localparam int HEAP_WORDS   = ffha_pkg::HEAP_WORDS_DEF;
	localparam int REQ_W        = ffha_pkg::REQ_W;
	localparam int SLOT_W       = ffha_pkg::SLOT_W;
	localparam int PLAN         = 0;
	localparam int CHK          = 1;
	localparam int RANDOM_ITEMS = 1100;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic              op;
		logic [REQ_W-1:0]  size;
		logic [SLOT_W-1:0] slot;
	} request_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot;
	} reply_t;

	logic                           clk;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [ffha_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                           s_tuser  = ffha_pkg::OP_ALLOC;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [ffha_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           m_tuser;

	logic [12:0] hdr     [2][HEAP_WORDS];
	bit          written [2][HEAP_WORDS];

	request_t    request_q[$];
	reply_t      reply_q[$];
	int unsigned live[$];

	int unsigned tx_wait, tx_run, rx_wait, rx_run, hold_left;
	int unsigned n_items, n_sent, n_results, mismatches, stall_count;
	int unsigned n_granted, n_refused, n_freed, top_slot;

	first_fit_heap_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void heap_clear(input int cp);
		for (int i = 0; i < HEAP_WORDS; i++) begin
			hdr[cp][i]     = '0;
			written[cp][i] = 1'b0;
		end
		hdr[cp][0]     = 13'((HEAP_WORDS - 1) * 8);
		written[cp][0] = 1'b1;
	endfunction

	function automatic reply_t heap_step(input int cp, input request_t rq);
		reply_t      rp;
		int unsigned need, idx, sz, nxt;
		rp.status = ffha_pkg::STATUS_OK;
		rp.slot   = '0;
		if (rq.op == ffha_pkg::OP_FREE) begin
			if (rq.slot != 0)
				hdr[cp][rq.slot - 1][0] = 1'b0;
			return rp;
		end
		need = (32'(rq.size) + 32'd7) & ~32'd7;
		idx  = 0;
		while (idx < HEAP_WORDS) begin
			sz = {hdr[cp][idx][12:1], 1'b0};
			if (!hdr[cp][idx][0] && sz >= need) begin
				if (sz > need) begin
					nxt = idx + need / 8 + 1;
					if (nxt < HEAP_WORDS) begin
						hdr[cp][nxt]     = 13'(sz - need - 8);
						written[cp][nxt] = 1'b1;
					end
				end
				hdr[cp][idx] = 13'(need) | 13'd1;
				rp.slot      = SLOT_W'(idx + 1);
				return rp;
			end
			idx += sz / 8 + 1;
		end
		rp.status = ffha_pkg::STATUS_FAIL;
		return rp;
	endfunction

	// ignored field of each request gets random content
	function automatic int unsigned queue_request(input logic op, input int unsigned arg);
		request_t rq;
		reply_t   rp;
		rq.op = op;
		if (op == ffha_pkg::OP_ALLOC) begin
			rq.size = REQ_W'(arg);
			rq.slot = SLOT_W'($urandom_range(0, 511));
		end else begin
			rq.size = REQ_W'($urandom);
			rq.slot = SLOT_W'(arg);
		end
		rp = heap_step(PLAN, rq);
		if (op == ffha_pkg::OP_ALLOC && rp.status == ffha_pkg::STATUS_OK && rp.slot != 0)
			live.push_back(rp.slot);
		if (op == ffha_pkg::OP_FREE) begin
			for (int k = 0; k < live.size(); k++) begin
				if (live[k] == rq.slot) begin
					live.delete(k);
					break;
				end
			end
		end
		request_q.push_back(rq);
		return rp.slot;
	endfunction

	function automatic int unsigned idle_cycles(inout int unsigned run);
		if (run != 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			run = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	initial begin : stimulus
		int unsigned a, b, c, d, e, r, sel, idx;
		heap_clear(PLAN);
		heap_clear(CHK);

		a = queue_request(ffha_pkg::OP_ALLOC, 0);
		b = queue_request(ffha_pkg::OP_ALLOC, 1);
		c = queue_request(ffha_pkg::OP_ALLOC, 8);
		d = queue_request(ffha_pkg::OP_ALLOC, 9);
		e = queue_request(ffha_pkg::OP_ALLOC, 16);
		void'(queue_request(ffha_pkg::OP_FREE, a));
		void'(queue_request(ffha_pkg::OP_ALLOC, 0));
		void'(queue_request(ffha_pkg::OP_FREE, c));
		void'(queue_request(ffha_pkg::OP_ALLOC, 7));
		void'(queue_request(ffha_pkg::OP_FREE, d));
		void'(queue_request(ffha_pkg::OP_ALLOC, 1));
		void'(queue_request(ffha_pkg::OP_ALLOC, 0));
		void'(queue_request(ffha_pkg::OP_FREE, 0));
		void'(queue_request(ffha_pkg::OP_FREE, b));
		void'(queue_request(ffha_pkg::OP_FREE, b));
		void'(queue_request(ffha_pkg::OP_ALLOC, 65535));
		void'(queue_request(ffha_pkg::OP_ALLOC, 65529));
		void'(queue_request(ffha_pkg::OP_ALLOC, 4088));
		a = queue_request(ffha_pkg::OP_ALLOC, 2000);
		void'(queue_request(ffha_pkg::OP_FREE, a));
		void'(queue_request(ffha_pkg::OP_ALLOC, 1000));
		void'(queue_request(ffha_pkg::OP_FREE, e));

		repeat (RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 52 || live.size() == 0) begin
				sel = $urandom_range(0, 19);
				if (sel < 14)
					void'(queue_request(ffha_pkg::OP_ALLOC, $urandom_range(0, 64)));
				else if (sel < 18)
					void'(queue_request(ffha_pkg::OP_ALLOC, $urandom_range(65, 400)));
				else if (sel < 19)
					void'(queue_request(ffha_pkg::OP_ALLOC, $urandom_range(0, 4088)));
				else
					void'(queue_request(ffha_pkg::OP_ALLOC, $urandom_range(0, 65535)));
			end else if (r < 92) begin
				void'(queue_request(ffha_pkg::OP_FREE,
					live[$urandom_range(0, live.size() - 1)]));
			end else if (r < 97) begin
				// any header ever written, busy or not
				idx = $urandom_range(0, HEAP_WORDS - 2);
				while (!written[PLAN][idx])
					idx = (idx == 0) ? HEAP_WORDS - 2 : idx - 1;
				void'(queue_request(ffha_pkg::OP_FREE, idx + 1));
			end else begin
				void'(queue_request(ffha_pkg::OP_FREE, 0));
			end
		end
		n_items = request_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent < n_items || reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests: %0d allocations granted, %0d refused, %0d frees",
			n_sent, n_granted, n_refused, n_freed);
		$display("highest payload slot granted %0d, %0d mismatches", top_slot, mismatches);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : request_driver
		request_t rq;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ffha_pkg::OP_ALLOC;
			tx_wait  <= 0;
		end else if (s_tvalid && !s_tready) begin
		end else if (tx_wait != 0) begin
			s_tvalid <= 1'b0;
			tx_wait  <= tx_wait - 1;
		end else if (request_q.size() != 0) begin
			rq = request_q.pop_front();
			s_tvalid <= 1'b1;
			s_tdata  <= {7'b0, rq.slot, rq.size};
			s_tuser  <= rq.op;
			tx_wait  <= idle_cycles(tx_run);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin : request_monitor
		request_t rq;
		reply_t   rp;
		if (arst_n && s_tvalid && s_tready) begin
			rq.op   = s_tuser;
			rq.size = s_tdata[15:0];
			rq.slot = s_tdata[24:16];
			rp = heap_step(CHK, rq);
			reply_q.push_back(rp);
			n_sent++;
			if (rq.op == ffha_pkg::OP_FREE)
				n_freed++;
			else if (rp.status == ffha_pkg::STATUS_FAIL)
				n_refused++;
			else begin
				n_granted++;
				if (rp.slot > top_slot)
					top_slot = rp.slot;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : reply_side
		reply_t      exp_r;
		int unsigned w, hl;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_wait   <= 0;
			hold_left <= 0;
		end else begin
			w  = rx_wait;
			hl = hold_left;
			if (m_tvalid && m_tready) begin
				n_results++;
				if (reply_q.size() == 0) begin
					$error("result transfer with nothing expected: status %0d slot %0d",
						m_tuser, m_tdata[SLOT_W-1:0]);
					mismatches++;
				end else begin
					exp_r = reply_q.pop_front();
					if (m_tuser !== exp_r.status) begin
						$error("status expected %0d got %0d", exp_r.status, m_tuser);
						mismatches++;
					end
					if (m_tdata[SLOT_W-1:0] !== exp_r.slot) begin
						$error("payload_slot expected %0d got %0d",
							exp_r.slot, m_tdata[SLOT_W-1:0]);
						mismatches++;
					end
				end
				w = idle_cycles(rx_run);
				if (n_results == HOLD_AFTER)
					hl = HOLD_CYCLES;
			end else if (w != 0) begin
				w = w - 1;
			end
			if (hl != 0)
				hl = hl - 1;
			rx_wait   <= w;
			hold_left <= hl;
			m_tready  <= (w == 0 && hl == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles, %0d results outstanding",
					stall_count, reply_q.size());
				$display("tb_top failed");
				$finish;
			end
		end
	end

endmodule

>>> first_fit_heap_allocator.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_hdr_mem.sv
rtl/core/first_fit_heap_allocator.sv
tb/tb_top.sv
